FILE: rtl/gcpd_pkg.sv
package gcpd_pkg;

  localparam int unsigned PixW      = 19;
  localparam int unsigned PixelCount = 1 << PixW;
  localparam int unsigned BitIdxW   = 4;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned CodeW     = 16;
  localparam int unsigned CountW    = 5;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 8;
  localparam int unsigned InDataW   = 40;
  localparam int unsigned OutDataW  = 40;

  localparam logic [CountW-1:0] MaxBits       = CountW'(16);
  localparam logic [CountW-1:0] BitCountReset = CountW'(10);

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMaskThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDropBits      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBitCount      = 2'd2;

  typedef struct packed {
    logic [PixW-1:0]  pixel_index;
    logic             code_valid;
    logic [CodeW-1:0] decoded_code;
  } result_t;

  function automatic logic [CodeW-1:0] gray_to_bin(input logic [CodeW-1:0] g);
    logic [CodeW-1:0] b;
    b = g;
    b = b ^ (b >> 1);
    b = b ^ (b >> 2);
    b = b ^ (b >> 4);
    b = b ^ (b >> 8);
    return b;
  endfunction

endpackage

FILE: rtl/gcpd_skid.sv
module gcpd_skid (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  gcpd_pkg::result_t res_i,
  output logic             adv_o,
  output logic             out_valid_o,
  output gcpd_pkg::result_t out_o,
  input  logic             out_ready_i
);
  import gcpd_pkg::*;

  logic    out_valid_q;
  logic    skid_valid_q;
  result_t out_q;
  result_t skid_q;

  // the pipeline moves whenever the spare slot is empty
  assign adv_o       = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= res_valid_i;
    end else if (res_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_q <= skid_q;
      end
    end else if (!out_valid_q || out_ready_i) begin
      out_q <= res_i;
    end else begin
      skid_q <= res_i;
    end
  end

endmodule

FILE: rtl/gray_code_pixel_decoder.sv
// Gray-code structured-light decoder, one pixel sample per transfer.
// Slave stream: one transfer carries a pixel index, the frame-pair number and
// the pixel's levels under the pattern frame and its inverse. Bit n of the
// pixel's code is gathered in an on-chip code memory (one 16-bit word per
// pixel); bit 0 starts a fresh word. Samples with a pair number past the
// last pair are dropped without effect.
// Master stream: on the last pair one transfer gives the pixel index, the
// decoded binary code (tdata) and the quality flag (tuser); an invalid pixel
// gives flag 0 and code 0.
// Config port: write enable, register index and data; written while idle.
// Throughput: one transfer per clock while the spare slot is empty (tready high),
// set by the single read-modify-write of the code memory (read port then
// write port, with a forwarding register for back-to-back samples of the same
// pixel). A sample is registered in the read stage and its result in the
// output register before it shows on the master side. When the receiver
// stalls, one result waits in the output register and one more in a spare
// slot; tready falls once the spare slot is used and rises again when it drains.
// Reset clears the pipeline, the output slots and the config registers
// (threshold 0, drop 0, bit count 10); the code memory is not cleared.
module gray_code_pixel_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [gcpd_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [gcpd_pkg::CfgDataW-1:0]    cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // pixel_index[18:0], bit_index[22:19], pattern_level[30:23],
  // inverse_level[38:31], zero [39]
  input  logic [gcpd_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // out_pixel_index[18:0], decoded_code[34:19], zero [39:35]
  output logic [gcpd_pkg::OutDataW-1:0]    m_axis_tdata,
  // code_valid[0]
  output logic                             m_axis_tuser
);
  import gcpd_pkg::*;

  logic [LevelW-1:0] thr_q;
  logic [CountW-1:0] drop_q;
  logic [CountW-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= '0;
      drop_q  <= '0;
      count_q <= BitCountReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMaskThreshold: thr_q   <= cfg_data_i;
        CfgDropBits:      drop_q  <= cfg_data_i[CountW-1:0];
        CfgBitCount:      count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  // input fields
  logic [PixW-1:0]    in_pix;
  logic [BitIdxW-1:0] in_bit;
  logic [LevelW-1:0]  in_pat;
  logic [LevelW-1:0]  in_inv;

  assign in_pix = s_axis_tdata[PixW-1:0];
  assign in_bit = s_axis_tdata[PixW+BitIdxW-1:PixW];
  assign in_pat = s_axis_tdata[PixW+BitIdxW+LevelW-1:PixW+BitIdxW];
  assign in_inv = s_axis_tdata[PixW+BitIdxW+2*LevelW-1:PixW+BitIdxW+LevelW];

  logic [CountW-1:0] eff_count;
  logic [CountW-1:0] last_bit;
  logic              adv;
  logic              accept;
  logic              in_used;

  always_comb begin
    if (count_q == '0) begin
      eff_count = CountW'(1);
    end else if (count_q > MaxBits) begin
      eff_count = MaxBits;
    end else begin
      eff_count = count_q;
    end
  end

  assign last_bit      = eff_count - CountW'(1);
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid & adv;
  assign in_used       = accept & ({1'b0, in_bit} <= last_bit);

  // read stage
  logic               s1_valid_q;
  logic               s1_last_q;
  logic [PixW-1:0]    s1_pix_q;
  logic [BitIdxW-1:0] s1_bit_q;
  logic [LevelW-1:0]  s1_pat_q;
  logic [LevelW-1:0]  s1_inv_q;
  logic               fwd_q;
  logic [CodeW-1:0]   fwd_data_q;
  logic [CodeW-1:0]   rd_q;
  logic [CodeW-1:0]   code_mem [PixelCount];

  logic [CodeW-1:0]   base;
  logic [CodeW-1:0]   new_entry;
  logic               mem_we;

  always_comb begin
    if (s1_bit_q == '0) begin
      base = '0;
    end else if (fwd_q) begin
      base = fwd_data_q;
    end else begin
      base = rd_q;
    end
    new_entry = base;
    if (s1_inv_q > s1_pat_q) begin
      new_entry = base | (CodeW'(1) << s1_bit_q);
    end
  end

  assign mem_we = s1_valid_q & adv;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      code_mem[s1_pix_q] <= new_entry;
    end
    if (adv) begin
      rd_q <= code_mem[in_pix];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_used;
      // the write of the item ahead lands on the same edge as this read
      fwd_q      <= s1_valid_q & (s1_pix_q == in_pix);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pix_q   <= in_pix;
      s1_bit_q   <= in_bit;
      s1_pat_q   <= in_pat;
      s1_inv_q   <= in_inv;
      s1_last_q  <= ({1'b0, in_bit} == last_bit);
      fwd_data_q <= new_entry;
    end
  end

  // result of the last pair
  logic [LevelW-1:0] diff;
  logic [CodeW-1:0]  keep_mask;
  result_t           res;
  result_t           out;

  always_comb begin
    if (s1_pat_q > s1_inv_q) begin
      diff = s1_pat_q - s1_inv_q;
    end else begin
      diff = s1_inv_q - s1_pat_q;
    end
    if (drop_q >= CountW'(CodeW)) begin
      keep_mask = '0;
    end else begin
      keep_mask = {CodeW{1'b1}} << drop_q[BitIdxW-1:0];
    end
    res.pixel_index  = s1_pix_q;
    res.code_valid   = diff > thr_q;
    res.decoded_code = res.code_valid ? (gray_to_bin(new_entry) & keep_mask) : '0;
  end

  gcpd_skid u_skid (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(s1_valid_q & s1_last_q),
    .res_i      (res),
    .adv_o      (adv),
    .out_valid_o(m_axis_tvalid),
    .out_o      (out),
    .out_ready_i(m_axis_tready)
  );

  assign m_axis_tdata = {(OutDataW - PixW - CodeW)'(0), out.decoded_code, out.pixel_index};
  assign m_axis_tuser = out.code_valid;

endmodule

FILE: bench/gray_code_pixel_decoder_tb.sv
module gray_code_pixel_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcpd_pkg::*;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  // index with no register behind it, written once to show it has no effect
  localparam logic [CfgIdxW-1:0] CfgUnused = 2'd3;

  typedef struct {
    logic [PixW-1:0]    pixel_index;
    logic [BitIdxW-1:0] bit_index;
    logic [LevelW-1:0]  pattern_level;
    logic [LevelW-1:0]  inverse_level;
    bit                 hold;
  } sample_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [CfgDataW-1:0]  cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;

  gray_code_pixel_decoder uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local copy of the registers and of the code memory
  logic [CfgDataW-1:0]  mask_thr_q = '0;
  logic [CountW-1:0]    drop_q = '0;
  logic [CountW-1:0]    bit_count_q = BitCountReset;
  logic [CodeW-1:0]     pixel_codes [int unsigned];

  sample_t              pending_samples [$];
  result_t              expected_results [$];
  sample_t              in_flight;
  result_t              predicted;
  idle_mode_e           idle_mode = IDLE_NONE;
  int unsigned          mismatch_count = 0;

  // stimulus bookkeeping: pixels whose bit 0 has been queued
  bit                   seeded [int unsigned];
  int unsigned          seeded_list [$];
  int unsigned          live_count;

  function automatic int unsigned last_pair_of(logic [CountW-1:0] cnt);
    if (cnt == 0) return 0;
    if (cnt > MaxBits) return MaxBits - 1;
    return cnt - 1;
  endfunction

  function automatic logic [CodeW-1:0] gray_decode(logic [CodeW-1:0] g);
    logic [CodeW-1:0] b;
    b[CodeW-1] = g[CodeW-1];
    for (int i = CodeW - 2; i >= 0; i--) b[i] = b[i+1] ^ g[i];
    return b;
  endfunction

  // updates the code memory for samples up to the last pair, returns 1 when the sample closes a pixel
  function automatic bit decode_sample(input sample_t s, output result_t r);
    int unsigned      last_pair;
    int unsigned      pix;
    int unsigned      gap;
    logic [CodeW-1:0] word;
    logic [CodeW-1:0] dec;
    last_pair = last_pair_of(bit_count_q);
    pix = s.pixel_index;
    r = '0;
    if (s.bit_index > last_pair) return 1'b0;
    word = '0;
    if (s.bit_index != 0 && pixel_codes.exists(pix)) word = pixel_codes[pix];
    if (s.inverse_level > s.pattern_level) word[s.bit_index] = 1'b1;
    pixel_codes[pix] = word;
    if (s.bit_index != last_pair) return 1'b0;
    gap = (s.pattern_level > s.inverse_level) ? s.pattern_level - s.inverse_level
                                               : s.inverse_level - s.pattern_level;
    r.pixel_index = s.pixel_index;
    if (gap > mask_thr_q) begin
      dec = gray_decode(word);
      if (drop_q >= CodeW) dec = '0;
      else dec = (dec >> drop_q) << drop_q;
      r.code_valid = 1'b1;
      r.decoded_code = dec;
    end
    return 1'b1;
  endfunction

  function automatic bit rest_now(bit sender);
    case (idle_mode)
      IDLE_SEND: return sender && $urandom_range(0, 99) < 46;
      IDLE_RECV: return !sender && $urandom_range(0, 99) < 46;
      IDLE_BOTH: return $urandom_range(0, 99) < 10;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%t  %s", $realtime, what);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_sample(in_flight, predicted))
          expected_results.insert(expected_results.size(), predicted);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 &&
            !(pending_samples[0].hold && expected_results.size() != 0) &&
            !rest_now(1'b1)) begin
          in_flight = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {1'b0, in_flight.inverse_level, in_flight.pattern_level,
                           in_flight.bit_index, in_flight.pixel_index};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          note_mismatch($sformatf("unexpected transfer: pixel %0d valid %0b code %h",
                                  m_axis_tdata[PixW-1:0], m_axis_tuser,
                                  m_axis_tdata[PixW+CodeW-1:PixW]));
        end else begin
          predicted = expected_results.pop_front();
          if (m_axis_tdata[PixW-1:0] !== predicted.pixel_index ||
              m_axis_tuser !== predicted.code_valid ||
              m_axis_tdata[PixW+CodeW-1:PixW] !== predicted.decoded_code)
            note_mismatch($sformatf(
              "expected pixel %0d valid %0b code %h, got pixel %0d valid %0b code %h",
              predicted.pixel_index, predicted.code_valid, predicted.decoded_code,
              m_axis_tdata[PixW-1:0], m_axis_tuser, m_axis_tdata[PixW+CodeW-1:PixW]));
        end
      end
      m_axis_tready <= !rest_now(1'b0);
    end
  end

  task automatic add_sample(int unsigned pix, int unsigned b, int unsigned pat,
                            int unsigned inv, bit hold);
    sample_t s;
    s.pixel_index = PixW'(pix);
    s.bit_index = BitIdxW'(b);
    s.pattern_level = LevelW'(pat);
    s.inverse_level = LevelW'(inv);
    s.hold = hold;
    if (b == 0 && !seeded.exists(pix)) begin
      seeded[pix] = 1'b1;
      seeded_list.insert(seeded_list.size(), pix);
    end
    if (b <= last_pair_of(bit_count_q)) live_count++;
    pending_samples.insert(pending_samples.size(), s);
  endtask

  function automatic int unsigned pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return PixelCount - 1;
      2, 3:    return $urandom_range(0, 15);
      default: return $urandom_range(0, PixelCount - 1);
    endcase
  endfunction

  // last pair: half the time the level gap sits within one of the threshold
  task automatic last_levels(output int unsigned pat, output int unsigned inv);
    int d;
    if ($urandom_range(0, 1)) begin
      pat = $urandom_range(0, 255);
      inv = $urandom_range(0, 255);
    end else begin
      d = mask_thr_q;
      d = d + int'($urandom_range(0, 2)) - 1;
      if (d < 0) d = 0;
      if (d > 255) d = 255;
      pat = $urandom_range(0, 255 - d);
      inv = pat + d;
      if ($urandom_range(0, 1)) begin
        inv = pat;
        pat = pat + d;
      end
    end
  endtask

  // one to three pixels scanned bit by bit, interleaved; some scans cut short
  task automatic add_scan_group(bit first_hold);
    int unsigned pix [3];
    int unsigned next_bit [3];
    int unsigned stop [3];
    int unsigned k, j, last_pair, pat, inv;
    bit          busy, hold;
    last_pair = last_pair_of(bit_count_q);
    k = $urandom_range(1, 3);
    hold = first_hold || $urandom_range(0, 79) == 0;
    for (j = 0; j < k; j++) begin
      pix[j] = pick_pixel();
      next_bit[j] = 0;
      stop[j] = ($urandom_range(0, 9) == 0) ? $urandom_range(0, last_pair) : last_pair;
    end
    forever begin
      busy = 1'b0;
      for (j = 0; j < k; j++) if (next_bit[j] <= stop[j]) busy = 1'b1;
      if (!busy) break;
      j = $urandom_range(0, k - 1);
      if (next_bit[j] > stop[j]) continue;
      if (next_bit[j] == last_pair) begin
        last_levels(pat, inv);
      end else begin
        pat = $urandom_range(0, 255);
        inv = $urandom_range(0, 255);
      end
      add_sample(pix[j], next_bit[j], pat, inv, hold);
      hold = 1'b0;
      next_bit[j]++;
    end
  endtask

  task automatic add_noise();
    int unsigned pix, b;
    if (seeded_list.size() != 0 && $urandom_range(0, 9) < 6)
      pix = seeded_list[$urandom_range(0, seeded_list.size() - 1)];
    else
      pix = pick_pixel();
    b = $urandom_range(0, 15);
    // never read a memory word that was not started with bit 0
    if (b != 0 && b <= last_pair_of(bit_count_q) && !seeded.exists(pix)) b = 0;
    add_sample(pix, b, $urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
  endtask

  task automatic fill(int unsigned target, bit first_hold);
    live_count = 0;
    while (live_count < target) begin
      if ($urandom_range(0, 99) < 72) begin
        add_scan_group(first_hold);
        first_hold = 1'b0;
      end else begin
        add_noise();
      end
    end
  endtask

  task automatic settle();
    do @(posedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_results.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgMaskThreshold: mask_thr_q = val;
      CfgDropBits:      drop_q = val[CountW-1:0];
      CfgBitCount:      bit_count_q = val[CountW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] thr, logic [CfgDataW-1:0] drop,
                           logic [CfgDataW-1:0] cnt, idle_mode_e mode, bit stray_write);
    settle();
    write_reg(CfgMaskThreshold, thr);
    write_reg(CfgDropBits, drop);
    write_reg(CfgBitCount, cnt);
    if (stray_write) write_reg(CfgUnused, CfgDataW'($urandom));
    @(posedge clk_i);
    idle_mode <= mode;
    fill(75, 1'b0);
  endtask

  initial begin
    int unsigned b;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: ten pairs, no threshold, no drop
    for (b = 0; b < 10; b++) add_sample(0, b, 0, 255, 1'b0);
    for (b = 0; b < 9; b++) add_sample(PixelCount - 1, b, 255, 0, 1'b0);
    add_sample(PixelCount - 1, 9, 255, 255, 1'b0);
    add_sample(5, 15, 0, 255, 1'b0);
    add_sample(0, 10, 255, 0, 1'b0);
    add_sample(0, 0, 17, 18, 1'b0);
    add_sample(0, 9, 200, 100, 1'b0);
    // first random scan waits for the output side to drain
    fill(60, 1'b1);

    run_phase(8'd255, 8'd0, 8'd16, IDLE_SEND, 1'b0);
    run_phase(8'd0, 8'd16, 8'd31, IDLE_RECV, 1'b0);
    run_phase(8'd37, 8'd3, 8'd1, IDLE_BOTH, 1'b0);
    run_phase(8'd128, 8'hFF, 8'd0, IDLE_NONE, 1'b0);
    run_phase(8'd5, 8'd15, 8'd4, IDLE_SEND, 1'b0);
    run_phase(8'd0, 8'd1, 8'hE7, IDLE_RECV, 1'b1);
    run_phase(8'd200, 8'd7, 8'd2, IDLE_BOTH, 1'b0);

    settle();
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("gray_code_pixel_decoder: match");
    end else begin
      $display("gray_code_pixel_decoder: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("gray_code_pixel_decoder: mismatch");
    $finish;
  end

endmodule

FILE: files.f
rtl/gcpd_pkg.sv
rtl/gcpd_skid.sv
rtl/gray_code_pixel_decoder.sv
bench/gray_code_pixel_decoder_tb.sv
